// ===== rtl/core/mjt_pkg.sv =====
// Shared types, constants and microcode encodings for the minimum-jerk
// trajectory generator. No dependencies.
package mjt_pkg;

    localparam int NUM_JOINTS = 7;
    localparam int POS_W      = 20;
    localparam int DUR_W      = 32;
    localparam int PER_W      = 16;
    localparam int ELAP_W     = 33;
    localparam int Q_W        = 17;
    localparam int MA_W       = 18;
    localparam int MB_W       = 22;
    localparam int PROD_W     = 40;
    localparam int POLY_W     = 20;
    localparam int JIDX_W     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int CFG_AW     = $clog2(NUM_JOINTS + 1);
    localparam int CFG_DW     = 32;

    localparam logic [CFG_AW-1:0] CFG_DURATION = CFG_AW'(0);
    localparam int                CFG_TARGET0  = 1;

    localparam logic [DUR_W-1:0]  DUR_RESET   = DUR_W'(20000000);
    localparam logic [ELAP_W-1:0] ELAP_MAX    = '1;
    localparam logic [Q_W-1:0]    ONE_Q16     = Q_W'(65536);
    localparam int                ROUND_HALF  = 32768;
    localparam int                C_TEN       = 10;
    localparam int                C_FIFTEEN   = 15;
    localparam int                C_SIX       = 6;

    typedef logic signed [POS_W-1:0] t_pos;

    localparam t_pos TGT_RESET [12] = '{
        t_pos'(0), t_pos'(-51446), t_pos'(0), t_pos'(-154403),
        t_pos'(0), t_pos'(102957), t_pos'(51446), t_pos'(0),
        t_pos'(0), t_pos'(0), t_pos'(0), t_pos'(0)
    };

    typedef struct packed {
        logic                        req_type;
        logic [PER_W-1:0]            tick_period_us;
        t_pos [NUM_JOINTS-1:0]       measured_pos;
    } t_in_beat;

    typedef struct packed {
        t_pos [NUM_JOINTS-1:0]       command_pos;
        logic                        done_res;
    } t_out_beat;

    localparam logic REQ_START = 1'b0;

    typedef enum logic [3:0] {
        OP_ACCEPT,
        OP_CMP,
        OP_DIVGO,
        OP_WAIT,
        OP_MTT,
        OP_RT2,
        OP_MT2T,
        OP_RT3,
        OP_MALPHA,
        OP_RALPHA,
        OP_MBLEND,
        OP_WBLEND,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_DISPATCH,
        J_OVER,
        J_DIVBUSY,
        J_JLOOP,
        J_OUTWAIT
    } t_jmp;

    typedef logic [3:0] t_addr;

    localparam t_addr A_IDLE    = 4'd0;
    localparam t_addr A_CMP     = 4'd1;
    localparam t_addr A_DIVGO   = 4'd2;
    localparam t_addr A_DIVWAIT = 4'd3;
    localparam t_addr A_MTT     = 4'd4;
    localparam t_addr A_RT2     = 4'd5;
    localparam t_addr A_MT2T    = 4'd6;
    localparam t_addr A_RT3     = 4'd7;
    localparam t_addr A_MALPHA  = 4'd8;
    localparam t_addr A_RALPHA  = 4'd9;
    localparam t_addr A_MBLEND  = 4'd10;
    localparam t_addr A_WBLEND  = 4'd11;
    localparam t_addr A_OUT     = 4'd12;

    typedef struct packed {
        t_op   op;
        t_jmp  jmp;
        t_addr target;
    } t_ucode;

    typedef struct packed {
        t_op op;
    } t_ctrl;

    typedef struct packed {
        logic accept;
        logic is_start;
        logic over;
        logic div_busy;
        logic jlast;
        logic out_free;
    } t_flags;

endpackage

// ===== rtl/core/mjt_div.sv =====
// Restoring divider: t = floor(num * 2^16 / den), one quotient bit per cycle.
// Assumes num <= den. Depends on mjt_pkg.
module mjt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [mjt_pkg::DUR_W-1:0]   i_num,
    input  logic [mjt_pkg::DUR_W-1:0]   i_den,
    output logic                        o_busy,
    output logic [mjt_pkg::Q_W-1:0]     o_quot
);
    localparam int CNT_W = $clog2(mjt_pkg::Q_W);

    logic                        r_busy;
    logic [CNT_W-1:0]            r_cnt;
    logic [mjt_pkg::DUR_W-1:0]   r_rem;
    logic                        r_lsb;
    logic [mjt_pkg::Q_W-1:0]     r_quot;

    logic [mjt_pkg::DUR_W-1:0]   w_den;
    logic [mjt_pkg::DUR_W:0]     w_shift;
    logic [mjt_pkg::DUR_W+1:0]   w_diff;
    logic                        w_bit;

    assign w_den   = (i_den == '0) ? mjt_pkg::DUR_W'(1) : i_den;
    assign w_bit   = (r_cnt == CNT_W'(mjt_pkg::Q_W - 1)) ? r_lsb : 1'b0;
    assign w_shift = {r_rem, w_bit};
    assign w_diff  = {1'b0, w_shift} - {2'b00, w_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(mjt_pkg::Q_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem  <= {1'b0, i_num[mjt_pkg::DUR_W-1:1]};
            r_lsb  <= i_num[0];
            r_quot <= '0;
        end else if (r_busy) begin
            if (!w_diff[mjt_pkg::DUR_W+1]) begin
                r_rem  <= w_diff[mjt_pkg::DUR_W-1:0];
                r_quot <= {r_quot[mjt_pkg::Q_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_shift[mjt_pkg::DUR_W-1:0];
                r_quot <= {r_quot[mjt_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;

endmodule

// ===== rtl/core/mjt_dpath.sv =====
// Datapath: config registers, trajectory state, shared multiplier, divider
// and output register. Driven by one op per cycle. Depends on mjt_pkg, mjt_div.
module mjt_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mjt_pkg::t_ctrl                i_ctrl,
    output mjt_pkg::t_flags               o_flags,
    input  logic                          i_cfg_we,
    input  logic [mjt_pkg::CFG_AW-1:0]    i_cfg_index,
    input  logic [mjt_pkg::CFG_DW-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mjt_pkg::t_in_beat             i_in_beat,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mjt_pkg::t_out_beat            o_out_beat
);
    localparam int NJ = mjt_pkg::NUM_JOINTS;

    logic [mjt_pkg::DUR_W-1:0]   r_dur;
    mjt_pkg::t_pos               r_tgt   [NJ];
    mjt_pkg::t_pos               r_start [NJ];
    mjt_pkg::t_pos               r_cmd   [NJ];
    logic                        r_done;
    logic [mjt_pkg::ELAP_W-1:0]  r_elapsed;
    logic [mjt_pkg::Q_W-1:0]     r_t2;
    logic [mjt_pkg::Q_W-1:0]     r_t3;
    logic [mjt_pkg::POLY_W-1:0]  r_poly;
    logic [mjt_pkg::Q_W-1:0]     r_alpha;
    logic signed [mjt_pkg::PROD_W-1:0] r_prod;
    logic [mjt_pkg::JIDX_W-1:0]  r_jidx;
    logic                        r_ovalid;
    mjt_pkg::t_out_beat          r_out;

    logic                        w_acc;
    logic                        w_over;
    logic                        w_free;
    logic                        w_div_go;
    logic                        w_div_busy;
    logic [mjt_pkg::Q_W-1:0]     w_t;
    logic [mjt_pkg::ELAP_W:0]    w_sum;
    logic signed [mjt_pkg::MA_W-1:0]   w_mul_a;
    logic signed [mjt_pkg::MB_W-1:0]   w_mul_b;
    logic signed [mjt_pkg::MB_W-1:0]   w_diff;
    logic signed [mjt_pkg::PROD_W-1:0] w_prod;
    logic signed [mjt_pkg::PROD_W-1:0] w_rnd;
    logic [23:0]                 w_poly;
    logic [23:0]                 w_alpha;

    assign w_acc    = i_in_valid && (i_ctrl.op == mjt_pkg::OP_ACCEPT);
    assign w_over   = r_elapsed > {1'b0, r_dur};
    assign w_free   = !r_ovalid || !i_out_stall;
    assign w_div_go = (i_ctrl.op == mjt_pkg::OP_DIVGO);
    assign w_sum    = {1'b0, r_elapsed} + (mjt_pkg::ELAP_W + 1)'(i_in_beat.tick_period_us);

    mjt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_div_go),
        .i_num   (r_elapsed[mjt_pkg::DUR_W-1:0]),
        .i_den   (r_dur),
        .o_busy  (w_div_busy),
        .o_quot  (w_t)
    );

    // shared multiplier operand select
    assign w_diff = mjt_pkg::MB_W'(r_tgt[r_jidx]) - mjt_pkg::MB_W'(r_start[r_jidx]);

    always_comb begin
        w_mul_a = mjt_pkg::MA_W'(w_t);
        w_mul_b = mjt_pkg::MB_W'(w_t);
        unique case (i_ctrl.op)
            mjt_pkg::OP_MT2T: begin
                w_mul_a = mjt_pkg::MA_W'(r_t2);
                w_mul_b = mjt_pkg::MB_W'(w_t);
            end
            mjt_pkg::OP_MALPHA: begin
                w_mul_a = mjt_pkg::MA_W'(r_t3);
                w_mul_b = mjt_pkg::MB_W'(r_poly);
            end
            mjt_pkg::OP_MBLEND: begin
                w_mul_a = mjt_pkg::MA_W'(r_alpha);
                w_mul_b = w_diff;
            end
            default: begin
                w_mul_a = mjt_pkg::MA_W'(w_t);
                w_mul_b = mjt_pkg::MB_W'(w_t);
            end
        endcase
    end

    assign w_prod  = w_mul_a * w_mul_b;
    assign w_rnd   = r_prod + mjt_pkg::PROD_W'(mjt_pkg::ROUND_HALF);
    // 10 - 15t + 6t^2 in Q16, t from divider, t2 registered
    assign w_poly  = 24'(mjt_pkg::C_TEN * 65536)
                   + 24'(r_t2) * 24'(mjt_pkg::C_SIX)
                   - 24'(w_t) * 24'(mjt_pkg::C_FIFTEEN);
    assign w_alpha = w_rnd[39:16];

    // control state: config, elapsed time, start pose, loop index, out valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur     <= mjt_pkg::DUR_RESET;
            r_elapsed <= '0;
            r_jidx    <= '0;
            r_ovalid  <= 1'b0;
            for (int j = 0; j < NJ; j++) begin
                r_tgt[j]   <= mjt_pkg::TGT_RESET[j];
                r_start[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == mjt_pkg::CFG_DURATION) begin
                    r_dur <= i_cfg_data;
                end
                for (int j = 0; j < NJ; j++) begin
                    if (i_cfg_index == mjt_pkg::CFG_AW'(mjt_pkg::CFG_TARGET0 + j)) begin
                        r_tgt[j] <= i_cfg_data[mjt_pkg::POS_W-1:0];
                    end
                end
            end
            if (w_acc) begin
                if (i_in_beat.req_type == mjt_pkg::REQ_START) begin
                    r_elapsed <= '0;
                    for (int j = 0; j < NJ; j++) begin
                        r_start[j] <= i_in_beat.measured_pos[j];
                    end
                end else if (w_sum[mjt_pkg::ELAP_W]) begin
                    r_elapsed <= mjt_pkg::ELAP_MAX;
                end else begin
                    r_elapsed <= w_sum[mjt_pkg::ELAP_W-1:0];
                end
            end
            if (i_ctrl.op == mjt_pkg::OP_RALPHA) begin
                r_jidx <= '0;
            end else if (i_ctrl.op == mjt_pkg::OP_WBLEND) begin
                r_jidx <= r_jidx + mjt_pkg::JIDX_W'(1);
            end
            if (i_ctrl.op == mjt_pkg::OP_OUT && w_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            mjt_pkg::OP_ACCEPT: begin
                if (w_acc && i_in_beat.req_type == mjt_pkg::REQ_START) begin
                    r_done <= 1'b0;
                    for (int j = 0; j < NJ; j++) begin
                        r_cmd[j] <= i_in_beat.measured_pos[j];
                    end
                end
            end
            mjt_pkg::OP_CMP: begin
                r_done <= w_over;
                if (w_over) begin
                    for (int j = 0; j < NJ; j++) begin
                        r_cmd[j] <= r_tgt[j];
                    end
                end
            end
            mjt_pkg::OP_MTT, mjt_pkg::OP_MT2T, mjt_pkg::OP_MALPHA,
            mjt_pkg::OP_MBLEND: begin
                r_prod <= w_prod;
            end
            mjt_pkg::OP_RT2: begin
                r_t2 <= w_rnd[16 +: mjt_pkg::Q_W];
            end
            mjt_pkg::OP_RT3: begin
                r_t3   <= w_rnd[16 +: mjt_pkg::Q_W];
                r_poly <= w_poly[23] ? '0 : w_poly[mjt_pkg::POLY_W-1:0];
            end
            mjt_pkg::OP_RALPHA: begin
                r_alpha <= (w_alpha > 24'(mjt_pkg::ONE_Q16)) ? mjt_pkg::ONE_Q16
                                                             : w_alpha[mjt_pkg::Q_W-1:0];
            end
            mjt_pkg::OP_WBLEND: begin
                r_cmd[r_jidx] <= r_start[r_jidx] + mjt_pkg::t_pos'(w_rnd[16 +: mjt_pkg::POS_W]);
            end
            mjt_pkg::OP_OUT: begin
                if (w_free) begin
                    r_out.done_res <= r_done;
                    for (int j = 0; j < NJ; j++) begin
                        r_out.command_pos[j] <= r_cmd[j];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_flags.accept   = w_acc;
    assign o_flags.is_start = (i_in_beat.req_type == mjt_pkg::REQ_START);
    assign o_flags.over     = w_over;
    assign o_flags.div_busy = w_div_busy;
    assign o_flags.jlast    = (r_jidx == mjt_pkg::JIDX_W'(NJ - 1));
    assign o_flags.out_free = w_free;

    assign o_in_stall  = (i_ctrl.op != mjt_pkg::OP_ACCEPT);
    assign o_out_valid = r_ovalid;
    assign o_out_beat  = r_out;

endmodule

// ===== rtl/core/mjt_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on mjt_pkg.
module mjt_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mjt_pkg::t_flags  i_flags,
    output mjt_pkg::t_ctrl   o_ctrl
);
    mjt_pkg::t_addr  r_pc;
    mjt_pkg::t_addr  n_pc;
    mjt_pkg::t_ucode w_uc;

    function automatic mjt_pkg::t_ucode ucode_rom(input mjt_pkg::t_addr a);
        mjt_pkg::t_ucode u;
        u = '{mjt_pkg::OP_WAIT, mjt_pkg::J_GOTO, mjt_pkg::A_IDLE};
        unique case (a)
            mjt_pkg::A_IDLE:    u = '{mjt_pkg::OP_ACCEPT, mjt_pkg::J_DISPATCH, mjt_pkg::A_OUT};
            mjt_pkg::A_CMP:     u = '{mjt_pkg::OP_CMP,    mjt_pkg::J_OVER,     mjt_pkg::A_OUT};
            mjt_pkg::A_DIVGO:   u = '{mjt_pkg::OP_DIVGO,  mjt_pkg::J_NEXT,     mjt_pkg::A_IDLE};
            mjt_pkg::A_DIVWAIT: u = '{mjt_pkg::OP_WAIT,   mjt_pkg::J_DIVBUSY,  mjt_pkg::A_IDLE};
            mjt_pkg::A_MTT:     u = '{mjt_pkg::OP_MTT,    mjt_pkg::J_NEXT,     mjt_pkg::A_IDLE};
            mjt_pkg::A_RT2:     u = '{mjt_pkg::OP_RT2,    mjt_pkg::J_NEXT,     mjt_pkg::A_IDLE};
            mjt_pkg::A_MT2T:    u = '{mjt_pkg::OP_MT2T,   mjt_pkg::J_NEXT,     mjt_pkg::A_IDLE};
            mjt_pkg::A_RT3:     u = '{mjt_pkg::OP_RT3,    mjt_pkg::J_NEXT,     mjt_pkg::A_IDLE};
            mjt_pkg::A_MALPHA:  u = '{mjt_pkg::OP_MALPHA, mjt_pkg::J_NEXT,     mjt_pkg::A_IDLE};
            mjt_pkg::A_RALPHA:  u = '{mjt_pkg::OP_RALPHA, mjt_pkg::J_NEXT,     mjt_pkg::A_IDLE};
            mjt_pkg::A_MBLEND:  u = '{mjt_pkg::OP_MBLEND, mjt_pkg::J_NEXT,     mjt_pkg::A_IDLE};
            mjt_pkg::A_WBLEND:  u = '{mjt_pkg::OP_WBLEND, mjt_pkg::J_JLOOP,    mjt_pkg::A_MBLEND};
            mjt_pkg::A_OUT:     u = '{mjt_pkg::OP_OUT,    mjt_pkg::J_OUTWAIT,  mjt_pkg::A_IDLE};
            default:            u = '{mjt_pkg::OP_WAIT,   mjt_pkg::J_GOTO,     mjt_pkg::A_IDLE};
        endcase
        return u;
    endfunction

    assign w_uc = ucode_rom(r_pc);

    always_comb begin
        n_pc = r_pc + mjt_pkg::t_addr'(1);
        unique case (w_uc.jmp)
            mjt_pkg::J_NEXT:     n_pc = r_pc + mjt_pkg::t_addr'(1);
            mjt_pkg::J_GOTO:     n_pc = w_uc.target;
            mjt_pkg::J_DISPATCH: begin
                if (!i_flags.accept) begin
                    n_pc = r_pc;
                end else if (i_flags.is_start) begin
                    n_pc = w_uc.target;
                end else begin
                    n_pc = r_pc + mjt_pkg::t_addr'(1);
                end
            end
            mjt_pkg::J_OVER:
                n_pc = i_flags.over ? w_uc.target : r_pc + mjt_pkg::t_addr'(1);
            mjt_pkg::J_DIVBUSY:
                n_pc = i_flags.div_busy ? r_pc : r_pc + mjt_pkg::t_addr'(1);
            mjt_pkg::J_JLOOP:
                n_pc = i_flags.jlast ? r_pc + mjt_pkg::t_addr'(1) : w_uc.target;
            mjt_pkg::J_OUTWAIT:
                n_pc = i_flags.out_free ? w_uc.target : r_pc;
            default:             n_pc = mjt_pkg::A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= mjt_pkg::A_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.op = w_uc.op;

endmodule

// ===== rtl/core/min_jerk_joint_trajectory.sv =====
// Top level of the minimum-jerk joint trajectory generator.
// Depends on mjt_pkg, mjt_seq, mjt_dpath.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------
//  in       | i_in_valid / o_in_stall | i_in_beat  (mjt_pkg::t_in_beat)
//  out      | o_out_valid / i_out_stall | o_out_beat (mjt_pkg::t_out_beat)
//  cfg      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One beat at a time. A start beat goes straight to the output register. A
// tick past the duration takes the compare step first; a tick in range also
// runs the 17-step divider and the shared multiplier for each joint.
// Synchronous active-low reset; config regs return to reset values.
// A result waiting under i_out_stall does not block the next input beat;
// the sequencer holds at its output step only if a second result is ready.
module min_jerk_joint_trajectory (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mjt_pkg::t_in_beat             i_in_beat,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mjt_pkg::t_out_beat            o_out_beat,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mjt_pkg::CFG_AW-1:0]    i_cfg_index,
    input  logic [mjt_pkg::CFG_DW-1:0]    i_cfg_data
);
    mjt_pkg::t_ctrl  w_ctrl;
    mjt_pkg::t_flags w_flags;
    logic            w_cfg_we;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    mjt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    mjt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_flags     (w_flags),
        .i_cfg_we    (w_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule

// ===== tb/sv/min_jerk_joint_trajectory_test.sv =====
// Self-checking bench for min_jerk_joint_trajectory: drives start/tick beats and register
// writes, predicts every command beat and checks it field by field.
// Depends on mjt_pkg and the min_jerk_joint_trajectory RTL.
`timescale 1ns / 1ps

module min_jerk_joint_trajectory_test;
    import mjt_pkg::*;

    localparam logic             REQ_TICK    = ~REQ_START;
    localparam t_pos             POS_MAX     = t_pos'(524287);
    localparam t_pos             POS_MIN     = t_pos'(-524288);
    localparam logic [PER_W-1:0] PER_MAX     = '1;
    localparam longint           UNIT        = longint'(ONE_Q16);
    localparam longint           ELAP_LIMIT  = longint'(ELAP_MAX);
    localparam int               RAND_CHUNK  = 78;
    localparam int               TAIL_CYCLES = 64;
    localparam int               RUN_TICKS   = 32;

    localparam int POSE_RAND  = 0;
    localparam int POSE_HI_LO = 1;
    localparam int POSE_LO_HI = 2;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    t_in_beat            in_beat   = '0;
    logic                out_stall = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [CFG_AW-1:0]   cfg_index = '0;
    logic [CFG_DW-1:0]   cfg_data  = '0;
    logic                in_stall;
    logic                out_valid;
    logic                cfg_ready;
    t_out_beat           out_beat;

    // trajectory state mirrored by the predictor
    longint              dur_ref;
    t_pos                tgt_ref  [NUM_JOINTS];
    longint              elapsed_ref;
    t_pos                pose_ref [NUM_JOINTS];

    t_in_beat            pending_q[$];
    t_out_beat           cmd_expect_q[$];
    int                  err_cnt        = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;

    min_jerk_joint_trajectory uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #(100_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint jerk_alpha(longint elapsed, longint dur);
        longint d, t, t2, t3, poly, a;
        d = (dur == 0) ? 1 : dur;
        t = (elapsed << 16) / d;
        if (t > UNIT) t = UNIT;
        t2 = (t * t + ROUND_HALF) >>> 16;
        t3 = (t2 * t + ROUND_HALF) >>> 16;
        poly = C_TEN * UNIT - C_FIFTEEN * t + C_SIX * t2;
        if (poly < 0) poly = 0;
        a = (t3 * poly + ROUND_HALF) >>> 16;
        if (a > UNIT) a = UNIT;
        return a;
    endfunction

    function automatic t_pos jerk_blend(t_pos s, t_pos g, longint a);
        longint q;
        q = (a * (longint'(g) - longint'(s)) + ROUND_HALF) >>> 16;
        return t_pos'(longint'(s) + q);
    endfunction

    function automatic t_out_beat traj_predict(t_in_beat b);
        t_out_beat r;
        longint    a;
        int        j;
        r = '0;
        if (b.req_type == REQ_START) begin
            for (j = 0; j < NUM_JOINTS; j++) begin
                pose_ref[j] = b.measured_pos[j];
                r.command_pos[j] = pose_ref[j];
            end
            elapsed_ref = 0;
        end else begin
            elapsed_ref += b.tick_period_us;
            if (elapsed_ref > ELAP_LIMIT) elapsed_ref = ELAP_LIMIT;
            if (elapsed_ref > dur_ref) begin
                for (j = 0; j < NUM_JOINTS; j++) r.command_pos[j] = tgt_ref[j];
                r.done_res = 1'b1;
            end else begin
                a = jerk_alpha(elapsed_ref, dur_ref);
                for (j = 0; j < NUM_JOINTS; j++)
                    r.command_pos[j] = jerk_blend(pose_ref[j], tgt_ref[j], a);
            end
        end
        return r;
    endfunction

    function automatic t_pos pattern_pos(int pattern, int j);
        case (pattern)
            POSE_HI_LO: return (j % 2 == 0) ? POS_MAX : POS_MIN;
            POSE_LO_HI: return (j % 2 == 0) ? POS_MIN : POS_MAX;
            default:    return t_pos'($urandom);
        endcase
    endfunction

    task automatic report(input string msg);
        err_cnt++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic queue_start(input int pattern);
        t_in_beat b;
        int       j;
        b.req_type       = REQ_START;
        b.tick_period_us = PER_W'($urandom);
        for (j = 0; j < NUM_JOINTS; j++) b.measured_pos[j] = pattern_pos(pattern, j);
        pending_q = {pending_q, b};
    endtask

    task automatic queue_tick(input int period);
        t_in_beat b;
        int       j;
        b.req_type       = REQ_TICK;
        b.tick_period_us = PER_W'(period);
        for (j = 0; j < NUM_JOINTS; j++) b.measured_pos[j] = t_pos'($urandom);
        pending_q = {pending_q, b};
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_DURATION) dur_ref = val;
        else tgt_ref[idx - CFG_TARGET0] = t_pos'(val);
    endtask

    task automatic load_targets(input int pattern);
        int j;
        for (j = 0; j < NUM_JOINTS; j++) begin
            if (pattern == POSE_RAND) write_reg(CFG_AW'(CFG_TARGET0 + j), $urandom);
            else write_reg(CFG_AW'(CFG_TARGET0 + j), CFG_DW'(pattern_pos(pattern, j)));
        end
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (pending_q.size() != 0 || in_valid || cmd_expect_q.size() != 0);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) cmd_expect_q = {cmd_expect_q, traj_predict(in_beat)};
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_beat  <= pending_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : monitor
        t_out_beat want;
        int        j;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            if (out_valid && !out_stall) begin
                if (cmd_expect_q.size() == 0) begin
                    report($sformatf("command beat with none expected: %h", out_beat));
                end else begin
                    want = cmd_expect_q.pop_front();
                    for (j = 0; j < NUM_JOINTS; j++)
                        if (out_beat.command_pos[j] !== want.command_pos[j])
                            report($sformatf("joint %0d command: expected %0d, got %0d", j,
                                $signed(want.command_pos[j]), $signed(out_beat.command_pos[j])));
                    if (out_beat.done_res !== want.done_res)
                        report($sformatf("done: expected %0b, got %0b",
                            want.done_res, out_beat.done_res));
                end
            end
        end
    end

    initial begin : stim
        int     phase, chunk, n, len, per, j;
        longint step;
        dur_ref     = DUR_RESET;
        elapsed_ref = 0;
        for (j = 0; j < NUM_JOINTS; j++) begin
            tgt_ref[j]  = TGT_RESET[j];
            pose_ref[j] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers, ticks before any start
        queue_tick(0);
        queue_tick(PER_MAX);
        queue_start(POSE_HI_LO);
        queue_tick(PER_MAX);
        queue_tick(12345);
        wait_idle();

        // shortest duration: t reaches exactly one, then done
        write_reg(CFG_DURATION, 1);
        load_targets(POSE_LO_HI);
        queue_start(POSE_HI_LO);
        queue_tick(0);
        queue_tick(1);
        queue_tick(1);
        queue_start(POSE_LO_HI);
        queue_tick(2);
        wait_idle();

        // zero duration
        write_reg(CFG_DURATION, 0);
        queue_start(POSE_RAND);
        queue_tick(0);
        queue_tick(1);
        wait_idle();

        write_reg(CFG_DURATION, '1);
        load_targets(POSE_HI_LO);
        queue_start(POSE_LO_HI);
        queue_tick(PER_MAX);
        queue_tick(PER_MAX);
        wait_idle();

        // sweep across the whole curve, landing exactly on the duration, then past it
        write_reg(CFG_DURATION, 100000);
        load_targets(POSE_RAND);
        queue_start(POSE_RAND);
        repeat (5) queue_tick(25000);
        wait_idle();

        for (phase = 0; phase < 4; phase++) begin
            for (chunk = 0; chunk < 3; chunk++) begin
                wait_idle();
                case (phase)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                    default: begin send_idle_pct = 21; recv_stall_pct = 21; end
                endcase
                case ($urandom_range(0, 7))
                    0: write_reg(CFG_DURATION, $urandom);
                    1: write_reg(CFG_DURATION, $urandom_range(0, 40));
                    default: write_reg(CFG_DURATION, $urandom_range(20000, 600000));
                endcase
                if ($urandom_range(0, 5) == 0) load_targets($urandom_range(1, 2));
                else load_targets(POSE_RAND);
                step = dur_ref / 5;
                if (step > 32767) step = 32767;
                if (step < 1) step = 1;
                n = 0;
                while (n < RAND_CHUNK) begin
                    if ($urandom_range(0, 4) == 0) begin
                        if ($urandom_range(0, 1) != 0) queue_tick($urandom_range(0, 65535));
                        else queue_start(POSE_RAND);
                        n++;
                    end else begin
                        queue_start(POSE_RAND);
                        n++;
                        len = $urandom_range(1, 12);
                        repeat (len) begin
                            case ($urandom_range(0, 7))
                                0: per = 0;
                                1: per = $urandom_range(0, 65535);
                                default: per = $urandom_range(0, int'(2 * step));
                            endcase
                            queue_tick(per);
                            n++;
                        end
                    end
                end
            end
        end

        // long run of maximum ticks past a short duration, then a wide one
        wait_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_reg(CFG_DURATION, 1);
        queue_start(POSE_RAND);
        repeat (RUN_TICKS) queue_tick(PER_MAX);
        wait_idle();
        write_reg(CFG_DURATION, '1);
        repeat (4) queue_tick(PER_MAX);
        queue_start(POSE_RAND);
        queue_tick(PER_MAX);
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
